// File: sv/dgr_pkg.sv
`default_nettype none

package dgr_pkg;

    // Graph size limit; rows and row widths of the adjacency memory follow it
    localparam int MAX_NODES = 64;
    localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    // Node number and node count field widths
    localparam int NUM_W = 8;
    localparam int CNT_W = 7;
    // Wide enough to hold both MAX_NODES and any node count
    localparam int ACT_W = 9;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd10;

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef logic [NODE_W-1:0]    t_node;
    typedef logic [MAX_NODES-1:0] t_row;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/dgr_ram.sv
`default_nettype none

module dgr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/directed_graph_reachability.sv
`default_nettype none

// Directed graph reachability engine. The graph lives in an adjacency memory of MAX_NODES rows
// (row s holds the edges leaving node s+1) plus one valid flip-flop per row, so reset, a
// node_count write and the clear command empty the graph at once with no clearing pass. Each
// input transaction is one command and gives exactly one result transaction. Clear and invalid
// commands go straight from idle to the done state; insert and delete read, modify and write back
// one row; a query is a search whose frontier drains one node per cycle through the single read
// port of the adjacency memory. A new command is accepted when the previous one has handed its
// result to the output register, even while that result waits.
module directed_graph_reachability (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [dgr_pkg::NUM_W-1:0]     i_src_node,
    input  logic [dgr_pkg::NUM_W-1:0]     i_dst_node,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_reachable,
    output logic                          o_status,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dgr_pkg::APB_AW-1:0]    paddr,
    input  logic [dgr_pkg::APB_DW-1:0]    pwdata,
    output logic [dgr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import dgr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MODIFY = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_node_count, n_node_count;
    t_row              r_row_vld, n_row_vld;
    t_row              r_frontier, n_frontier;
    t_row              r_visited, n_visited;
    logic              r_rd_pend, n_rd_pend;
    t_node             r_rd_addr;
    t_node             r_src, n_src;
    t_node             r_dst, n_dst;
    logic              r_insert, n_insert;
    logic              r_res_reach, n_res_reach;
    logic              r_res_status, n_res_status;
    logic              r_out_vld, n_out_vld;
    logic              r_reachable, n_reachable;
    logic              r_status, n_status;

    logic              in_acc;
    logic              cfg_wr;
    logic [ACT_W-1:0]  active;
    logic              src_ok, dst_ok;
    t_node             src_idx, dst_idx;
    t_node             rd_addr;
    logic              we;
    t_row              wdata;
    t_row              ram_q;
    t_row              rd_row;
    t_row              fresh;
    t_row              dst_mask;
    t_row              pick_mask;
    t_node             pick_idx;
    t_cmd              cmd;

    assign cmd    = t_cmd'(i_command);
    assign in_acc = i_in_valid && o_in_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Saturate node count to the memory size
    assign active = (ACT_W'(r_node_count) > ACT_W'(MAX_NODES)) ? ACT_W'(MAX_NODES)
                                                              : ACT_W'(r_node_count);
    assign src_ok = (i_src_node != '0) && (ACT_W'(i_src_node) <= active);
    assign dst_ok = (i_dst_node != '0) && (ACT_W'(i_dst_node) <= active);
    assign src_idx = NODE_W'(i_src_node - NUM_W'(1));
    assign dst_idx = NODE_W'(i_dst_node - NUM_W'(1));

    // Rows never written since the last clear read as empty
    assign rd_row = r_row_vld[r_rd_addr] ? ram_q : '0;

    // Lowest pending frontier node
    always_comb begin
        pick_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (r_frontier[i]) begin
                pick_idx = NODE_W'(i);
            end
        end
        pick_mask = '0;
        pick_mask[pick_idx] = 1'b1;
        dst_mask = '0;
        dst_mask[r_dst] = 1'b1;
    end

    // Nodes newly reached through the row that just came back
    assign fresh = r_rd_pend ? (rd_row & ~r_visited) : '0;

    // Control and datapath next state
    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_row_vld    = r_row_vld;
        n_frontier   = r_frontier;
        n_visited    = r_visited;
        n_rd_pend    = 1'b0;
        n_src        = r_src;
        n_dst        = r_dst;
        n_insert     = r_insert;
        n_res_reach  = r_res_reach;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_reachable  = r_reachable;
        n_status     = r_status;
        rd_addr      = r_rd_addr;
        we           = 1'b0;
        wdata        = r_insert ? (rd_row | dst_mask) : (rd_row & ~dst_mask);

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = src_idx;
                n_src   = src_idx;
                n_dst   = dst_idx;
                if (in_acc) begin
                    n_res_reach  = 1'b0;
                    n_res_status = 1'b0;
                    n_insert     = (cmd == CMD_INSERT);
                    priority if (cmd == CMD_CLEAR) begin
                        n_row_vld = '0;
                        n_state   = ST_DONE;
                    end else if (!src_ok || !dst_ok) begin
                        n_res_status = 1'b1;
                        n_state      = ST_DONE;
                    end else if (cmd == CMD_QUERY) begin
                        // Source row arrives next cycle and seeds both sets
                        n_frontier = '0;
                        n_visited  = '0;
                        n_rd_pend  = 1'b1;
                        n_state    = ST_SEARCH;
                    end else begin
                        n_state = ST_MODIFY;
                    end
                end
            end
            ST_MODIFY: begin
                // Write back the source row with the edge set or dropped
                we               = 1'b1;
                n_row_vld[r_src] = 1'b1;
                n_state          = ST_DONE;
            end
            ST_SEARCH: begin
                n_visited = r_visited | fresh;
                if (r_frontier != '0) begin
                    // Pop one node and fetch its row
                    rd_addr    = pick_idx;
                    n_rd_pend  = 1'b1;
                    n_frontier = (r_frontier & ~pick_mask) | fresh;
                end else begin
                    n_frontier = fresh;
                end
                if ((r_frontier == '0) && !r_rd_pend) begin
                    n_res_reach = r_visited[r_dst];
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld   = 1'b1;
                    n_reachable = r_res_reach;
                    n_status    = r_res_status;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A node count write also empties the graph
        if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
            n_node_count = pwdata[CNT_W-1:0];
            n_row_vld    = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= NODE_COUNT_RESET;
            r_row_vld    <= '0;
            r_rd_pend    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_row_vld    <= n_row_vld;
            r_rd_pend    <= n_rd_pend;
            r_out_vld    <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_frontier   <= n_frontier;
        r_visited    <= n_visited;
        r_rd_addr    <= rd_addr;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_insert     <= n_insert;
        r_res_reach  <= n_res_reach;
        r_res_status <= n_res_status;
        r_reachable  <= n_reachable;
        r_status     <= n_status;
    end

    dgr_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_src),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_reachable = r_reachable;
    assign o_status    = r_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DW'(r_node_count) : '0;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dgr_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int IDX_NODE_COUNT = int'(REG_NODE_COUNT);
    // First index past the register list; writes there must be ignored
    localparam int IDX_SPARE      = 1;
    localparam int NO_CFG         = -1;
    localparam int FROM_GRAPH     = -1;

    typedef struct packed {
        logic reach;
        logic status;
    } t_result;

    typedef struct packed {
        logic             set_cfg;
        logic [CNT_W-1:0] cfg_val;
        t_cmd             op;
        logic [NUM_W-1:0] src;
        logic [NUM_W-1:0] dst;
        logic             typed;
        logic             reach;
        logic             status;
    } t_dir_row;

    // Clock, reset and block inputs, all known from time zero
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              cmd_valid  = 1'b0;
    t_cmd              cmd_op     = CMD_INSERT;
    logic [NUM_W-1:0]  cmd_src    = '0;
    logic [NUM_W-1:0]  cmd_dst    = '0;
    logic              rsp_ready  = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [APB_DW-1:0] pwdata     = '0;

    logic              cmd_ready;
    logic              rsp_valid;
    logic              rsp_reachable;
    logic              rsp_status;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Hand-typed expectation that travels with the command being driven
    logic              cmd_typed      = 1'b0;
    t_result           cmd_typed_res  = '0;

    // Graph model state
    t_row              graph_rows [MAX_NODES];
    logic [CNT_W-1:0]  node_cfg;

    t_result           expected_results [$];
    t_dir_row          dir_rows [$];

    int                errors      = 0;
    int                cycles      = 0;
    int                burst_left  = 0;
    int                n_accepted  = 0;
    int                n_queries   = 0;
    int                n_reached   = 0;
    int                n_rejected  = 0;
    int                n_settings  = 0;

    directed_graph_reachability dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_command   (cmd_op),
        .i_src_node  (cmd_src),
        .i_dst_node  (cmd_dst),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_reachable (rsp_reachable),
        .o_status    (rsp_status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int active_nodes();
        return (int'(node_cfg) > MAX_NODES) ? MAX_NODES : int'(node_cfg);
    endfunction

    function automatic bit node_in_range(logic [NUM_W-1:0] n);
        return (n >= 1) && (int'(n) <= active_nodes());
    endfunction

    function automatic void clear_graph();
        for (int r = 0; r < MAX_NODES; r++) graph_rows[r] = '0;
    endfunction

    // Search from row s: pop the lowest frontier node, add its unvisited successors
    function automatic logic path_exists(int s, int d);
        t_row frontier;
        t_row seen;
        t_row fresh;
        int   node;
        frontier = graph_rows[s];
        seen     = graph_rows[s];
        for (int step = 0; step < MAX_NODES; step++) begin
            if (frontier == '0) break;
            node = 0;
            while (!frontier[node]) node++;
            frontier[node] = 1'b0;
            fresh    = graph_rows[node] & ~seen;
            frontier = frontier | fresh;
            seen     = seen | fresh;
        end
        return seen[d];
    endfunction

    // Apply one command to the graph model and return its result
    function automatic t_result graph_step(t_cmd op, logic [NUM_W-1:0] src,
                                           logic [NUM_W-1:0] dst);
        t_result res;
        int      s;
        int      d;
        res = '0;
        s   = int'(src) - 1;
        d   = int'(dst) - 1;
        if (op == CMD_CLEAR) begin
            clear_graph();
        end else if (!node_in_range(src) || !node_in_range(dst)) begin
            res.status = 1'b1;
        end else begin
            case (op)
                CMD_INSERT: graph_rows[s][d] = 1'b1;
                CMD_DELETE: graph_rows[s][d] = 1'b0;
                default:    res.reach = path_exists(s, d);
            endcase
        end
        return res;
    endfunction

    // Monitor: predict on every accepted command, check every accepted result
    always @(posedge i_clk) begin : monitor
        t_result pred;
        t_result exp_res;
        if (i_rst_n) begin
            if (cmd_valid && cmd_ready) begin
                pred = graph_step(cmd_op, cmd_src, cmd_dst);
                expected_results.push_back(cmd_typed ? cmd_typed_res : pred);
                n_accepted++;
                if (cmd_op == CMD_QUERY) n_queries++;
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: reachable=%0b status=%0b",
                           rsp_reachable, rsp_status);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (rsp_reachable !== exp_res.reach) begin
                        $error("reachable: expected %0b, actual %0b", exp_res.reach,
                               rsp_reachable);
                        errors++;
                    end
                    if (rsp_status !== exp_res.status) begin
                        $error("status: expected %0b, actual %0b", exp_res.status,
                               rsp_status);
                        errors++;
                    end
                    if (rsp_reachable === 1'b1) n_reached++;
                    if (rsp_status === 1'b1) n_rejected++;
                end
            end
        end
    end

    // Receiver: stall in modes of random length
    always @(negedge i_clk) begin : receiver
        static int mode      = 0;
        static int mode_left = 0;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
            0:       rsp_ready = 1'b1;
            1:       rsp_ready = $urandom_range(0, 1);
            2:       rsp_ready = ($urandom_range(0, 7) == 0);
            default: rsp_ready = (cycles % 4 != 0);
        endcase
    end

    // Drive one command transaction, holding it until accepted
    task automatic send_cmd(t_cmd op, logic [NUM_W-1:0] src, logic [NUM_W-1:0] dst,
                            logic typed, t_result typed_res);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            cmd_valid = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            repeat (gap - 1) @(negedge i_clk);
            if (gap > 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        cmd_valid     = 1'b1;
        cmd_op        = op;
        cmd_src       = src;
        cmd_dst       = dst;
        cmd_typed     = typed;
        cmd_typed_res = typed_res;
        do @(posedge i_clk); while (!(cmd_valid && cmd_ready));
    endtask

    // Hold off input until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        cmd_valid = 1'b0;
        cmd_typed = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(idx * 4);
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == IDX_NODE_COUNT) begin
            node_cfg = data[CNT_W-1:0];
            clear_graph();
            n_settings++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read node_count back and compare with the model
    task automatic check_node_count();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = APB_AW'(IDX_NODE_COUNT * 4);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(node_cfg)) begin
            $error("prdata: expected %0d, actual %0d", node_cfg, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic add_row(int cfg, t_cmd op, int src, int dst, int reach, int status);
        t_dir_row row;
        row.set_cfg = (cfg != NO_CFG);
        row.cfg_val = CNT_W'(cfg);
        row.op      = op;
        row.src     = NUM_W'(src);
        row.dst     = NUM_W'(dst);
        row.typed   = (reach != FROM_GRAPH);
        row.reach   = reach[0];
        row.status  = status[0];
        dir_rows.push_back(row);
    endtask

    // Node number: mostly in range, sometimes zero, past the count or all ones
    function automatic logic [NUM_W-1:0] pick_node();
        int act;
        act = active_nodes();
        if (act > 0 && $urandom_range(0, 99) < 88) return NUM_W'($urandom_range(1, act));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return NUM_W'($urandom_range(act + 1, 255));
        endcase
    endfunction

    // Random commands plus chains that end in queries along the whole chain, both ways
    task automatic run_random(int n_items);
        int   sent;
        int   pick;
        int   act;
        int   len;
        int   first;
        t_cmd op;
        sent = 0;
        while (sent < n_items) begin
            act = active_nodes();
            if (act >= 2 && $urandom_range(0, 99) < 8) begin
                len   = ($urandom_range(0, 3) == 0) ? $urandom_range(2, act)
                                                    : $urandom_range(2, (act < 8) ? act : 8);
                first = $urandom_range(1, act - len + 1);
                for (int k = 0; k < len - 1; k++)
                    send_cmd(CMD_INSERT, NUM_W'(first + k), NUM_W'(first + k + 1), 1'b0, '0);
                send_cmd(CMD_QUERY, NUM_W'(first), NUM_W'(first + len - 1), 1'b0, '0);
                send_cmd(CMD_QUERY, NUM_W'(first + len - 1), NUM_W'(first), 1'b0, '0);
                sent += len + 1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      op = CMD_INSERT;
                else if (pick < 60) op = CMD_DELETE;
                else if (pick < 97) op = CMD_QUERY;
                else                op = CMD_CLEAR;
                send_cmd(op, pick_node(), pick_node(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Move to a new node count, poke the spare address, and confirm the readback
    task automatic set_node_count(int value);
        drain_results();
        apb_write(IDX_SPARE, $urandom);
        apb_write(IDX_NODE_COUNT, APB_DW'(value));
        check_node_count();
    endtask

    initial begin : stimulus
        int settings [8];
        node_cfg = NODE_COUNT_RESET;
        clear_graph();

        // Directed rows; node count starts at its reset value of 10
        add_row(NO_CFG, CMD_QUERY,  1,   1,   0, 0);
        add_row(NO_CFG, CMD_INSERT, 1,   2,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_INSERT, 2,   3,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_QUERY,  1,   3,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_INSERT, 3,   1,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_QUERY,  1,   1,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_INSERT, 1,   2,   0, 0);
        add_row(NO_CFG, CMD_DELETE, 5,   6,   0, 0);
        add_row(NO_CFG, CMD_DELETE, 2,   3,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_QUERY,  1,   3,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_INSERT, 0,   1,   0, 1);
        add_row(NO_CFG, CMD_QUERY,  11,  1,   0, 1);
        add_row(NO_CFG, CMD_QUERY,  255, 255, 0, 1);
        add_row(NO_CFG, CMD_INSERT, 10,  10,  0, 0);
        add_row(NO_CFG, CMD_QUERY,  10,  10,  FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_CLEAR,  0,   255, 0, 0);
        add_row(NO_CFG, CMD_QUERY,  10,  10,  0, 0);
        // No nodes at all
        add_row(0,      CMD_INSERT, 1,   1,   0, 1);
        add_row(NO_CFG, CMD_CLEAR,  255, 0,   0, 0);
        // Count above the limit saturates
        add_row(127,    CMD_INSERT, 64,  64,  0, 0);
        add_row(NO_CFG, CMD_QUERY,  64,  64,  FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_INSERT, 65,  1,   0, 1);
        // Single node with a self loop
        add_row(1,      CMD_INSERT, 1,   1,   0, 0);
        add_row(NO_CFG, CMD_QUERY,  1,   1,   FROM_GRAPH, 0);
        add_row(NO_CFG, CMD_QUERY,  2,   1,   0, 1);

        // Hold reset, then release it
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        check_node_count();
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg) set_node_count(int'(dir_rows[i].cfg_val));
            send_cmd(dir_rows[i].op, dir_rows[i].src, dir_rows[i].dst, dir_rows[i].typed,
                     '{reach: dir_rows[i].reach, status: dir_rows[i].status});
        end

        // Random phases over a range of node counts
        settings = '{64, 6, 127, 2, $urandom_range(3, 63), 0, $urandom_range(65, 126), 10};
        foreach (settings[p]) begin
            set_node_count(settings[p]);
            if (settings[p] == 0) begin
                run_random(20);
            end else if (p == 0) begin
                run_random(55);
                // Pause input until the block has handed back everything
                drain_results();
                run_random(55);
            end else begin
                run_random(110);
            end
        end

        drain_results();
        repeat (80) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result transactions never arrived", expected_results.size());
            errors++;
        end

        $display("Ran %0d commands over %0d node_count settings: %0d queries, %0d reachable,",
                 n_accepted, n_settings, n_queries, n_reached);
        $display("%0d rejected for node range; chains of up to 64 nodes queried both ways.",
                 n_rejected);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
